// ===== rtl/core/vsp_pkg.sv =====
package vsp_pkg;

	// Number format and store geometry
	localparam int FRAC_BITS  = 16;
	localparam int COEF_WIDTH = 32;
	localparam int NUM_COEF   = 24;
	localparam int ACC_W      = 68;
	localparam int PROD_W     = 66;
	localparam int COEF_SH    = (COEF_WIDTH < 32) ? 32 - COEF_WIDTH : 0;

	// Reciprocal divider geometry
	localparam int NUM_W = 2 * FRAC_BITS + 2;
	localparam int CNT_W = $clog2(NUM_W + 1);

	// Configuration port
	localparam int PADDR_W = 3;
	localparam logic REG_ORTHO = 1'b0;

	// Commands and status codes
	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_PROJECT = 1'b1;
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SAT    = 2'd1;
	localparam logic [1:0] ST_ZDEPTH = 2'd2;

	// Coefficient store layout
	localparam logic [4:0] CI_MAT = 5'd0;
	localparam logic [4:0] CI_P1  = 5'd12;
	localparam logic [4:0] CI_P2  = 5'd13;
	localparam logic [4:0] CI_P3  = 5'd14;
	localparam logic [4:0] CI_P4  = 5'd15;
	localparam logic [4:0] CI_P5  = 5'd16;
	localparam logic [4:0] CI_P6  = 5'd17;
	localparam logic [4:0] CI_VX  = 5'd18;
	localparam logic [4:0] CI_VY  = 5'd19;
	localparam logic [4:0] CI_VW  = 5'd20;
	localparam logic [4:0] CI_VH  = 5'd21;
	localparam logic [4:0] CI_VN  = 5'd22;
	localparam logic [4:0] CI_VF  = 5'd23;

	// Micro-op kinds
	localparam logic [2:0] K_LDC  = 3'd0;
	localparam logic [2:0] K_MUL0 = 3'd1;
	localparam logic [2:0] K_MAC  = 3'd2;
	localparam logic [2:0] K_ADDC = 3'd3;
	localparam logic [2:0] K_SUBC = 3'd4;
	localparam logic [2:0] K_HALF = 3'd5;
	localparam logic [2:0] K_DIV  = 3'd6;

	// Multiplier operand A sources
	localparam logic [3:0] A_X   = 4'd0;
	localparam logic [3:0] A_Y   = 4'd1;
	localparam logic [3:0] A_Z   = 4'd2;
	localparam logic [3:0] A_EX  = 4'd3;
	localparam logic [3:0] A_EY  = 4'd4;
	localparam logic [3:0] A_EZ  = 4'd5;
	localparam logic [3:0] A_W   = 4'd6;
	localparam logic [3:0] A_NX  = 4'd7;
	localparam logic [3:0] A_NNY = 4'd8;
	localparam logic [3:0] A_NZ  = 4'd9;

	// Multiplier operand B sources
	localparam logic [2:0] B_COEF = 3'd0;
	localparam logic [2:0] B_CX   = 3'd1;
	localparam logic [2:0] B_CY   = 3'd2;
	localparam logic [2:0] B_CZ   = 3'd3;
	localparam logic [2:0] B_T    = 3'd4;

	// Destinations
	localparam logic [3:0] D_NONE = 4'd0;
	localparam logic [3:0] D_EX   = 4'd1;
	localparam logic [3:0] D_EY   = 4'd2;
	localparam logic [3:0] D_EZ   = 4'd3;
	localparam logic [3:0] D_CX   = 4'd4;
	localparam logic [3:0] D_CY   = 4'd5;
	localparam logic [3:0] D_CZ   = 4'd6;
	localparam logic [3:0] D_NX   = 4'd7;
	localparam logic [3:0] D_NY   = 4'd8;
	localparam logic [3:0] D_NZ   = 4'd9;
	localparam logic [3:0] D_T    = 4'd10;
	localparam logic [3:0] D_SX   = 4'd11;
	localparam logic [3:0] D_SY   = 4'd12;
	localparam logic [3:0] D_SD   = 4'd13;

	// Program landmarks
	localparam logic [5:0] PC_EZ_END    = 6'd11;
	localparam logic [5:0] PC_PERSP_END = 6'd21;
	localparam logic [5:0] PC_ORTHO     = 6'd22;
	localparam logic [5:0] PC_VIEW      = 6'd28;
	localparam logic [5:0] PC_LAST      = 6'd39;

	typedef struct packed {
		logic [4:0] addr;
		logic [2:0] kind;
		logic [3:0] asel;
		logic [2:0] bsel;
		logic [3:0] dst;
	} uop_t;

	typedef struct packed {
		logic               ovf;
		logic signed [31:0] v;
	} sat_t;

	// Keep the low COEF_WIDTH bits of a loaded word, sign-extended
	function automatic logic signed [31:0] load_coef(input logic [31:0] v);
		logic [31:0] s;
		s = v << COEF_SH;
		return $signed(s) >>> COEF_SH;
	endfunction

	// Clamp an accumulator value to the signed 32-bit range
	function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
		sat_t r;
		r.ovf = !((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31]));
		if (r.ovf) begin
			r.v = v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			r.v = v[31:0];
		end
		return r;
	endfunction

	function automatic uop_t mk(input logic [4:0] a, input logic [2:0] k,
			input logic [3:0] s, input logic [2:0] b, input logic [3:0] d);
		uop_t u;
		u.addr = a;
		u.kind = k;
		u.asel = s;
		u.bsel = b;
		u.dst  = d;
		return u;
	endfunction

	// Micro-program: eye transform, perspective, orthographic, viewport
	function automatic uop_t uop_at(input logic [5:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = mk(CI_MAT + 5'd3,  K_LDC,  A_X,   B_COEF, D_NONE);
			6'd1:  u = mk(CI_MAT + 5'd2,  K_MAC,  A_Z,   B_COEF, D_NONE);
			6'd2:  u = mk(CI_MAT + 5'd0,  K_MAC,  A_X,   B_COEF, D_NONE);
			6'd3:  u = mk(CI_MAT + 5'd1,  K_MAC,  A_Y,   B_COEF, D_EX);
			6'd4:  u = mk(CI_MAT + 5'd7,  K_LDC,  A_X,   B_COEF, D_NONE);
			6'd5:  u = mk(CI_MAT + 5'd6,  K_MAC,  A_Z,   B_COEF, D_NONE);
			6'd6:  u = mk(CI_MAT + 5'd4,  K_MAC,  A_X,   B_COEF, D_NONE);
			6'd7:  u = mk(CI_MAT + 5'd5,  K_MAC,  A_Y,   B_COEF, D_EY);
			6'd8:  u = mk(CI_MAT + 5'd11, K_LDC,  A_X,   B_COEF, D_NONE);
			6'd9:  u = mk(CI_MAT + 5'd10, K_MAC,  A_Z,   B_COEF, D_NONE);
			6'd10: u = mk(CI_MAT + 5'd8,  K_MAC,  A_X,   B_COEF, D_NONE);
			6'd11: u = mk(CI_MAT + 5'd9,  K_MAC,  A_Y,   B_COEF, D_EZ);
			6'd12: u = mk(CI_P1, K_MUL0, A_EX,  B_COEF, D_NONE);
			6'd13: u = mk(CI_P2, K_MAC,  A_EZ,  B_COEF, D_CX);
			6'd14: u = mk(CI_P3, K_MUL0, A_EY,  B_COEF, D_NONE);
			6'd15: u = mk(CI_P4, K_MAC,  A_EZ,  B_COEF, D_CY);
			6'd16: u = mk(CI_P6, K_LDC,  A_EZ,  B_COEF, D_NONE);
			6'd17: u = mk(CI_P5, K_MAC,  A_EZ,  B_COEF, D_CZ);
			6'd18: u = mk(CI_P1, K_DIV,  A_EZ,  B_COEF, D_NONE);
			6'd19: u = mk(CI_P1, K_MUL0, A_W,   B_CX,   D_NX);
			6'd20: u = mk(CI_P1, K_MUL0, A_W,   B_CY,   D_NY);
			6'd21: u = mk(CI_P1, K_MUL0, A_W,   B_CZ,   D_NZ);
			6'd22: u = mk(CI_P2, K_LDC,  A_EX,  B_COEF, D_NONE);
			6'd23: u = mk(CI_P1, K_MAC,  A_EX,  B_COEF, D_NX);
			6'd24: u = mk(CI_P4, K_LDC,  A_EY,  B_COEF, D_NONE);
			6'd25: u = mk(CI_P3, K_MAC,  A_EY,  B_COEF, D_NY);
			6'd26: u = mk(CI_P6, K_LDC,  A_EZ,  B_COEF, D_NONE);
			6'd27: u = mk(CI_P5, K_MAC,  A_EZ,  B_COEF, D_NZ);
			6'd28: u = mk(CI_VF, K_LDC,  A_NZ,  B_COEF, D_NONE);
			6'd29: u = mk(CI_VN, K_SUBC, A_NZ,  B_COEF, D_T);
			6'd30: u = mk(CI_VW, K_LDC,  A_NX,  B_COEF, D_NONE);
			6'd31: u = mk(CI_VW, K_MAC,  A_NX,  B_COEF, D_NONE);
			6'd32: u = mk(CI_VW, K_HALF, A_NX,  B_COEF, D_NONE);
			6'd33: u = mk(CI_VX, K_ADDC, A_NX,  B_COEF, D_SX);
			6'd34: u = mk(CI_VH, K_LDC,  A_NNY, B_COEF, D_NONE);
			6'd35: u = mk(CI_VH, K_MAC,  A_NNY, B_COEF, D_NONE);
			6'd36: u = mk(CI_VH, K_HALF, A_NNY, B_COEF, D_NONE);
			6'd37: u = mk(CI_VY, K_ADDC, A_NNY, B_COEF, D_SY);
			6'd38: u = mk(CI_VF, K_LDC,  A_NZ,  B_T,    D_NONE);
			6'd39: u = mk(CI_VF, K_MAC,  A_NZ,  B_T,    D_SD);
			default: u = mk(CI_MAT, K_LDC, A_X, B_COEF, D_NONE);
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/core/vsp_in_if.sv =====
interface vsp_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [4:0]         coef_index;
	logic signed [31:0] coef_value;
	logic signed [31:0] vert_x;
	logic signed [31:0] vert_y;
	logic signed [31:0] vert_z;

	modport source (output valid, command, coef_index, coef_value, vert_x, vert_y, vert_z,
		input ready);
	modport sink (input valid, command, coef_index, coef_value, vert_x, vert_y, vert_z,
		output ready);
endinterface

// ===== rtl/core/vsp_out_if.sv =====
interface vsp_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;
	logic signed [31:0] screen_depth;
	logic [1:0]         status;

	modport source (output valid, screen_x, screen_y, screen_depth, status, input ready);
	modport sink (input valid, screen_x, screen_y, screen_depth, status, output ready);
endinterface

// ===== rtl/core/vsp_recip.sv =====
module vsp_recip (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] ez,
	output logic               busy,
	output logic               done,
	output logic signed [31:0] value,
	output logic               ovf
);
	import vsp_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [32:0]      d_q;
	logic [32:0]      rem_q;
	logic [NUM_W-1:0] n_q;
	logic [NUM_W-1:0] q_q;

	logic [32:0] d_in;
	logic [33:0] trial;
	logic        fit;
	logic [63:0] q_ext;
	logic [32:0] q_clamp;
	logic signed [33:0] r_signed;

	// Magnitude of the eye depth
	assign d_in = ez[31] ? 33'(-$signed({ez[31], ez})) : {1'b0, ez};

	// One restoring step per cycle
	assign trial = {rem_q, n_q[NUM_W-1]};
	assign fit   = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= ez[31];
			d_q   <= d_in;
			rem_q <= '0;
			q_q   <= '0;
			n_q   <= (NUM_W'(1) << (2 * FRAC_BITS)) + NUM_W'(d_in >> 1);
		end else if (busy_q) begin
			rem_q <= fit ? 33'(trial - {1'b0, d_q}) : trial[32:0];
			q_q   <= {q_q[NUM_W-2:0], fit};
			n_q   <= n_q << 1;
		end
	end

	// Clamp the quotient, apply the sign of 1/(-ez), saturate
	assign q_ext    = 64'(q_q);
	assign q_clamp  = (q_ext > 64'h8000_0000) ? 33'h0_8000_0000 : q_ext[32:0];
	assign r_signed = neg_q ? $signed({1'b0, q_clamp}) : -$signed({1'b0, q_clamp});
	assign ovf      = r_signed > 34'sh0_7fff_ffff;
	assign value    = ovf ? 32'sh7fff_ffff : r_signed[31:0];
	assign busy     = busy_q;
	assign done     = done_q;
endmodule

// ===== rtl/core/vertex_screen_projection.sv =====
// Vertex projection unit. A load transaction (command 0) writes one of 24 Q16.16
// coefficients; indexes 24 to 31 are dropped. A project transaction (command 1)
// runs a micro-program on one shared multiply-accumulate datapath fed from the
// coefficient RAM: each step has a RAM read, a registered multiply, and an
// accumulate and saturate phase. Eye transform and viewport take 24 steps;
// orthographic adds 6 steps; perspective adds 9 steps plus a divide step (34
// bit-serial reciprocal iterations). No transaction is taken until the result
// of the running program has moved to the output register. A zero eye depth in
// perspective ends the program after the eye transform. The result sits in an
// output register, so the next transaction is taken while it waits.
// Coefficients read as zero until written after reset.
module vertex_screen_projection (
	input  logic                          clk,
	input  logic                          arst_n,
	vsp_in_if.sink                        in_ch,
	vsp_out_if.source                     out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vsp_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import vsp_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	localparam logic [1:0] PH_READ = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] ph_q;
	logic [5:0] pc_q;
	logic       sat_q;
	logic       zd_q;
	logic       ortho_q;
	logic       out_valid_q;

	logic signed [31:0] mem [NUM_COEF];
	logic [NUM_COEF-1:0] vld_q;
	logic signed [31:0] rdata_q;
	logic               rvld_q;

	logic signed [31:0] x_q, y_q, z_q, ex_q, ey_q, ez_q, cx_q, cy_q, cz_q;
	logic signed [31:0] w_q, nx_q, ny_q, nz_q, t_q, sx_q, sy_q, sd_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [31:0] osx_q, osy_q, osd_q;
	logic [1:0]         ost_q;

	uop_t               uop;
	logic               in_acc;
	logic               we;
	logic signed [31:0] coef;
	logic signed [32:0] a_op;
	logic signed [32:0] b_op;
	logic signed [PROD_W-1:0] mres_w;
	logic signed [ACC_W-1:0]  mres;
	logic signed [ACC_W-1:0]  coef_x;
	logic signed [ACC_W-1:0]  acc_nx;
	sat_t               sr;
	logic               exec;
	logic               zero_hit;
	logic               finish;
	logic               div_start;
	logic               div_busy;
	logic               div_done;
	logic signed [31:0] div_val;
	logic               div_ovf;
	logic               out_free;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ORTHO) ? {31'b0, ortho_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ortho_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == REG_ORTHO) begin
			ortho_q <= pwdata[0];
		end
	end

	// Handshake
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign we = in_acc && in_ch.command == CMD_LOAD && in_ch.coef_index < 5'(NUM_COEF);
	assign out_free = !out_valid_q || out_ch.ready;

	// Coefficient RAM; loads only happen while no program runs
	assign uop = uop_at(pc_q);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[in_ch.coef_index] <= load_coef(in_ch.coef_value);
		end
		rdata_q <= mem[uop.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[in_ch.coef_index] <= 1'b1;
			end
			rvld_q <= vld_q[uop.addr];
		end
	end

	assign coef = rvld_q ? rdata_q : 32'sd0;

	// Operand selection
	always_comb begin
		case (uop.asel)
			A_X:     a_op = 33'(x_q);
			A_Y:     a_op = 33'(y_q);
			A_Z:     a_op = 33'(z_q);
			A_EX:    a_op = 33'(ex_q);
			A_EY:    a_op = 33'(ey_q);
			A_EZ:    a_op = 33'(ez_q);
			A_W:     a_op = 33'(w_q);
			A_NX:    a_op = 33'(nx_q);
			A_NNY:   a_op = -33'(ny_q);
			A_NZ:    a_op = 33'(nz_q);
			default: a_op = 33'(x_q);
		endcase
		case (uop.bsel)
			B_COEF:  b_op = 33'(coef);
			B_CX:    b_op = 33'(cx_q);
			B_CY:    b_op = 33'(cy_q);
			B_CZ:    b_op = 33'(cz_q);
			B_T:     b_op = 33'(t_q);
			default: b_op = 33'(coef);
		endcase
	end

	// Round half up, then accumulate
	assign mres_w = (prod_q + (PROD_W'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
	assign mres   = ACC_W'(mres_w);
	assign coef_x = ACC_W'(coef);

	always_comb begin
		case (uop.kind)
			K_LDC:   acc_nx = coef_x;
			K_MUL0:  acc_nx = mres;
			K_MAC:   acc_nx = acc_q + mres;
			K_ADDC:  acc_nx = acc_q + coef_x;
			K_SUBC:  acc_nx = acc_q - coef_x;
			K_HALF:  acc_nx = (acc_q + ACC_W'(1)) >>> 1;
			default: acc_nx = acc_q;
		endcase
	end

	assign sr = sat32(acc_nx);

	// Sequencer control
	assign div_start = state_q == S_RUN && uop.kind == K_DIV && ph_q == PH_READ;
	assign exec = state_q == S_RUN &&
		((uop.kind != K_DIV && ph_q == PH_EXEC) ||
		 (uop.kind == K_DIV && ph_q == PH_MUL && div_done));
	assign zero_hit = exec && pc_q == PC_EZ_END && !ortho_q && acc_nx == '0;
	assign finish   = exec && (pc_q == PC_LAST || zero_hit);

	vsp_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.ez     (ez_q),
		.busy   (div_busy),
		.done   (div_done),
		.value  (div_val),
		.ovf    (div_ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= PH_READ;
			pc_q        <= '0;
			sat_q       <= 1'b0;
			zd_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// present a finished result, or drop the one just taken
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && in_ch.command == CMD_PROJECT) begin
						state_q <= S_RUN;
						pc_q    <= '0;
						ph_q    <= PH_READ;
						sat_q   <= 1'b0;
						zd_q    <= 1'b0;
					end
				end
				S_RUN: begin
					// advance the phase; a divide waits in the multiply phase
					if (uop.kind == K_DIV) begin
						ph_q <= div_done ? PH_READ : PH_MUL;
					end else begin
						ph_q <= (ph_q == PH_EXEC) ? PH_READ : ph_q + 2'd1;
					end
					if (exec) begin
						if ((uop.dst != D_NONE && sr.ovf) || (uop.kind == K_DIV && div_ovf)) begin
							sat_q <= 1'b1;
						end
						if (finish) begin
							state_q <= S_OUT;
							zd_q    <= zero_hit;
						end else if (pc_q == PC_EZ_END && ortho_q) begin
							pc_q <= PC_ORTHO;
						end else if (pc_q == PC_PERSP_END) begin
							pc_q <= PC_VIEW;
						end else begin
							pc_q <= pc_q + 6'd1;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= in_ch.vert_x;
			y_q <= in_ch.vert_y;
			z_q <= in_ch.vert_z;
		end
		if (ph_q == PH_MUL) begin
			prod_q <= PROD_W'(a_op * b_op);
		end
		if (exec) begin
			acc_q <= acc_nx;
			if (uop.kind == K_DIV) begin
				w_q <= div_val;
			end
			case (uop.dst)
				D_EX:    ex_q <= sr.v;
				D_EY:    ey_q <= sr.v;
				D_EZ:    ez_q <= sr.v;
				D_CX:    cx_q <= sr.v;
				D_CY:    cy_q <= sr.v;
				D_CZ:    cz_q <= sr.v;
				D_NX:    nx_q <= sr.v;
				D_NY:    ny_q <= sr.v;
				D_NZ:    nz_q <= sr.v;
				D_T:     t_q  <= sr.v;
				D_SX:    sx_q <= sr.v;
				D_SY:    sy_q <= sr.v;
				D_SD:    sd_q <= sr.v;
				default: ;
			endcase
		end
		// load the output register
		if (state_q == S_OUT && out_free) begin
			osx_q <= zd_q ? 32'sd0 : sx_q;
			osy_q <= zd_q ? 32'sd0 : sy_q;
			osd_q <= zd_q ? 32'sd0 : sd_q;
			ost_q <= zd_q ? ST_ZDEPTH : (sat_q ? ST_SAT : ST_OK);
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.screen_x     = osx_q;
	assign out_ch.screen_y     = osy_q;
	assign out_ch.screen_depth = osd_q;
	assign out_ch.status       = ost_q;

	// Checks
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("reciprocal started while busy");
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> pc_q <= PC_LAST) else $error("program counter out of range");
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q != 2'd3) else $error("illegal step phase");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ost_q != 2'd3) else $error("illegal status code");
endmodule
